[design/allux_pkg.sv]
// Shared types, constants and the control program of the ambient light lux block.
// No dependencies; imported by ambient_light_lux_autorange, allux_checker and tb.
`timescale 1ns / 1ps
`default_nettype none

package allux_pkg;

    localparam int LUX_FRAC_BITS_DEF = 8;

    // Port widths
    localparam int RAW_W      = 16;
    localparam int LUX_W      = 40;
    localparam int GAIN_W     = 2;
    localparam int TIME_W     = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Datapath widths
    localparam int A36_W      = 22;   // raw * 36
    localparam int Q_W        = 13;   // (raw * 36) / 625
    localparam int P_W        = 25;   // lux in Q.8
    localparam int T_W        = 61;   // polynomial temporaries
    localparam int MUL_A_W    = 40;
    localparam int MUL_HALF_W = 20;
    localparam int MUL_B_W    = 32;
    localparam int ACC_W      = 64;

    // Division by 625 as multiply by reciprocal; exact for dividends below 2^31
    localparam int               RECIP_SHIFT = 41;
    localparam logic [31:0]      RECIP_625   = 32'd3518437209;
    localparam logic [9:0]       DIV_625     = 10'd625;

    // High-lux correction coefficients
    localparam logic [23:0]      COEF4 = 24'd11092950;
    localparam logic [37:0]      COEF3 = 38'd173259199038;
    localparam logic [34:0]      COEF2 = 35'd22936832902;
    localparam logic [48:0]      COEF1 = 49'd282122369157091;

    // Gain codes
    localparam logic [GAIN_W-1:0] GAIN_EIGHTH  = 2'd0;
    localparam logic [GAIN_W-1:0] GAIN_QUARTER = 2'd1;
    localparam logic [GAIN_W-1:0] GAIN_X1      = 2'd2;
    localparam logic [GAIN_W-1:0] GAIN_X2      = 2'd3;

    // Integration time codes
    localparam logic [TIME_W-1:0] TIME_25MS  = 3'd0;
    localparam logic [TIME_W-1:0] TIME_50MS  = 3'd1;
    localparam logic [TIME_W-1:0] TIME_100MS = 3'd2;
    localparam logic [TIME_W-1:0] TIME_200MS = 3'd3;
    localparam logic [TIME_W-1:0] TIME_400MS = 3'd4;
    localparam logic [TIME_W-1:0] TIME_800MS = 3'd5;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_VERY_BRIGHT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BRIGHT      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VERY_DARK   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DARK        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_EN    = 3'd4;

    localparam logic [15:0] VERY_BRIGHT_RST = 16'd60000;
    localparam logic [15:0] BRIGHT_RST      = 16'd30000;
    localparam logic [15:0] VERY_DARK_RST   = 16'd100;
    localparam logic [15:0] DARK_RST        = 16'd500;

    typedef enum logic {
        SEQ_IDLE,
        SEQ_RUN
    } seq_state_t;

    typedef enum logic [3:0] {
        OP_MUL_LO,    // acc = a[19:0] * b
        OP_MUL_HI,    // acc += (a[39:20] * b) << 20
        OP_QUOT,      // coarse quotient, high-lux flag
        OP_REM,       // remainder and coarse quotient scaled
        OP_LIN,       // linear lux = coarse + fine quotient
        OP_PSCALE,    // lux to Q.8
        OP_T1,
        OP_POS,
        OP_HB,
        OP_HC,
        OP_FIN_FIX,   // corrected lux to output
        OP_FIN_LIN    // linear lux to output
    } uop_t;

    typedef enum logic [2:0] {
        A_RAW36,
        A_X,
        A_C4,
        A_T,
        A_C3,
        A_HB8,
        A_HC24
    } asel_t;

    typedef enum logic {
        B_RECIP,
        B_P
    } bsel_t;

    typedef enum logic {
        JMP_NONE,
        JMP_LOW_LUX
    } jmp_t;

    localparam int STEP_W = 5;
    localparam logic [STEP_W-1:0] STEP_JMP     = 5'd6;
    localparam logic [STEP_W-1:0] STEP_FIX_OUT = 5'd22;
    localparam logic [STEP_W-1:0] STEP_LIN_OUT = 5'd23;
    localparam logic [STEP_W-1:0] LAST_STEP    = 5'd23;

    typedef struct packed {
        uop_t              op;
        asel_t             asel;
        bsel_t             bsel;
        jmp_t              jmp;
        logic [STEP_W-1:0] target;
        logic              done;
    } uword_t;

    function automatic logic [2:0] gain_shift(input logic [GAIN_W-1:0] g);
        logic [2:0] s;
        unique case (g)
            GAIN_EIGHTH:  s = 3'd0;
            GAIN_QUARTER: s = 3'd1;
            GAIN_X1:      s = 3'd3;
            GAIN_X2:      s = 3'd4;
            default:      s = 3'd3;
        endcase
        return s;
    endfunction

    function automatic uword_t uw(input uop_t op, input asel_t a, input bsel_t b);
        uword_t w;
        w.op     = op;
        w.asel   = a;
        w.bsel   = b;
        w.jmp    = JMP_NONE;
        w.target = '0;
        w.done   = 1'b0;
        return w;
    endfunction

    // Control program. Steps 0..6 form the linear conversion, 7..21 the
    // high-lux polynomial, 22/23 the two ways out.
    function automatic uword_t ucode(input logic [STEP_W-1:0] step);
        uword_t w;
        w = uw(OP_FIN_LIN, A_RAW36, B_RECIP);
        unique case (step)
            5'd0:  w = uw(OP_MUL_LO, A_RAW36, B_RECIP);
            5'd1:  w = uw(OP_MUL_HI, A_RAW36, B_RECIP);
            5'd2:  w = uw(OP_QUOT,   A_RAW36, B_RECIP);
            5'd3:  w = uw(OP_REM,    A_RAW36, B_RECIP);
            5'd4:  w = uw(OP_MUL_LO, A_X,     B_RECIP);
            5'd5:  w = uw(OP_MUL_HI, A_X,     B_RECIP);
            5'd6: begin
                w        = uw(OP_LIN, A_X, B_RECIP);
                w.jmp    = JMP_LOW_LUX;
                w.target = STEP_LIN_OUT;
            end
            5'd7:  w = uw(OP_PSCALE, A_RAW36, B_P);
            5'd8:  w = uw(OP_MUL_LO, A_C4,    B_P);
            5'd9:  w = uw(OP_MUL_HI, A_C4,    B_P);
            5'd10: w = uw(OP_T1,     A_C4,    B_P);
            5'd11: w = uw(OP_MUL_LO, A_T,     B_P);
            5'd12: w = uw(OP_MUL_HI, A_T,     B_P);
            5'd13: w = uw(OP_POS,    A_T,     B_P);
            5'd14: w = uw(OP_MUL_LO, A_C3,    B_P);
            5'd15: w = uw(OP_MUL_HI, A_C3,    B_P);
            5'd16: w = uw(OP_HB,     A_C3,    B_P);
            5'd17: w = uw(OP_MUL_LO, A_HB8,   B_P);
            5'd18: w = uw(OP_MUL_HI, A_HB8,   B_P);
            5'd19: w = uw(OP_HC,     A_HB8,   B_P);
            5'd20: w = uw(OP_MUL_LO, A_HC24,  B_P);
            5'd21: w = uw(OP_MUL_HI, A_HC24,  B_P);
            5'd22: begin
                w      = uw(OP_FIN_FIX, A_HC24, B_P);
                w.done = 1'b1;
            end
            5'd23: begin
                w      = uw(OP_FIN_LIN, A_RAW36, B_RECIP);
                w.done = 1'b1;
            end
            default: w.done = 1'b1;
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

[design/ambient_light_lux_autorange.sv]
// Ambient light lux conversion with automatic gain / integration-time ranging.
// Microcoded sequencer around one shared 20x32 multiplier; uses allux_pkg.
`timescale 1ns / 1ps
`default_nettype none

// One raw count in, one result out. The count is converted to lux (Q.F,
// F = LUX_FRAC_BITS) with the gain and integration time in effect, corrected
// by the high-lux polynomial above 1000 lux, and the settings for the next
// sample are picked from the count and the four limits. An item takes more
// program steps when the correction is needed than when it is not: every
// product goes through the single 20x32 multiplier in two halves, and the
// correction needs five products in sequence. One item is in work at a time;
// the next transfer is taken as soon as the result sits in the output
// register, even if the downstream side has not taken it yet. Configuration
// writes are taken every cycle and must only happen while the block is idle.
module ambient_light_lux_autorange
    import allux_pkg::*;
#(
    parameter int LUX_FRAC_BITS = LUX_FRAC_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [RAW_W-1:0]      s_raw_count,

    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [LUX_W-1:0]      m_lux_fixed,
    output logic [GAIN_W-1:0]     m_gain_used,
    output logic [TIME_W-1:0]     m_time_used,
    output logic [GAIN_W-1:0]     m_next_gain,
    output logic [TIME_W-1:0]     m_next_time,
    output logic                  m_settings_changed
);

    localparam int SH_MAX    = LUX_FRAC_BITS + 5;
    localparam int SH_W      = $clog2(SH_MAX + 1);
    localparam int NUM_W     = A36_W + SH_MAX;
    localparam int LIN_W     = 17 + LUX_FRAC_BITS;
    localparam int X_W       = 10 + SH_MAX;
    localparam int FIX_SHIFT = 32 - LUX_FRAC_BITS;
    localparam logic [NUM_W-1:0] HI_LIMIT = NUM_W'(64'd625000 << LUX_FRAC_BITS);

    // Control
    seq_state_t        state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              out_valid_reg, out_valid_next;
    logic [GAIN_W-1:0] gain_idx_reg, gain_idx_next;
    logic [TIME_W-1:0] time_idx_reg, time_idx_next;
    logic [15:0]       very_bright_reg, bright_reg, very_dark_reg, dark_reg;
    logic              range_en_reg;

    // Datapath
    logic [RAW_W-1:0]  raw_reg, raw_next;
    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic [Q_W-1:0]    q_reg, q_next;
    logic              hi_reg, hi_next;
    logic [X_W-1:0]    x_reg, x_next;
    logic [LIN_W-1:0]  l_reg, l_next;
    logic [P_W-1:0]    p_reg, p_next;
    logic [T_W-1:0]    t_reg, t_next;

    // Output register
    logic [LUX_W-1:0]  lux_out_reg, lux_out_next;
    logic [GAIN_W-1:0] gain_out_reg, gain_out_next, ngain_out_reg, ngain_out_next;
    logic [TIME_W-1:0] time_out_reg, time_out_next, ntime_out_reg, ntime_out_next;
    logic              chg_out_reg, chg_out_next;

    uword_t                      ctl;
    logic                        s_xfer, stall, step_en;
    logic [TIME_W-1:0]           teff;
    logic [SH_W-1:0]             shamt;
    logic [A36_W-1:0]            a36, q625;
    logic [9:0]                  rem10;
    logic [NUM_W-1:0]            num;
    logic [MUL_A_W-1:0]          mul_a;
    logic [MUL_B_W-1:0]          mul_b;
    logic [MUL_HALF_W-1:0]       a_half;
    logic [MUL_HALF_W+MUL_B_W-1:0] prod;
    logic [T_W-1:0]              neg;
    logic [ACC_W-1:0]            fix_val;
    logic [LUX_W-1:0]            fix_sat;
    logic [P_W-1:0]              p_scaled;
    logic [GAIN_W-1:0]           ng;
    logic [TIME_W-1:0]           nt;
    logic                        changed;

    assign ctl = ucode(step_reg);

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        s_ready = (state_reg == SEQ_IDLE);
        s_xfer  = s_valid && s_ready;
        // Hold the last step while the previous result is still waiting
        stall   = (state_reg == SEQ_RUN) && ctl.done && out_valid_reg && !m_ready;
        step_en = (state_reg == SEQ_RUN) && !stall;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            SEQ_IDLE: begin
                if (s_valid) begin
                    state_next = SEQ_RUN;
                end
            end
            SEQ_RUN: begin
                if (step_en && ctl.done) begin
                    state_next = SEQ_IDLE;
                end
            end
            default: state_next = SEQ_IDLE;
        endcase
    end

    always_comb begin
        step_next = step_reg;
        if (s_xfer) begin
            step_next = '0;
        end else if (step_en) begin
            if (ctl.jmp == JMP_LOW_LUX && !hi_reg) begin
                step_next = ctl.target;
            end else begin
                step_next = step_reg + STEP_W'(1);
            end
        end
    end

    // ------------------------------------------------------------------
    // Datapath
    // ------------------------------------------------------------------
    always_comb begin
        teff  = (time_idx_reg > TIME_800MS) ? TIME_100MS : time_idx_reg;
        shamt = SH_W'(SH_MAX) - SH_W'(teff) - SH_W'(gain_shift(gain_idx_reg));
        a36   = A36_W'({raw_reg, 5'b0}) + A36_W'({raw_reg, 2'b0});
        num   = NUM_W'(a36) << shamt;
        q625  = A36_W'(q_reg) * A36_W'(DIV_625);
        rem10 = 10'(a36 - q625);
    end

    always_comb begin
        unique case (ctl.asel)
            A_RAW36: mul_a = MUL_A_W'(a36);
            A_X:     mul_a = MUL_A_W'(x_reg);
            A_C4:    mul_a = MUL_A_W'(COEF4);
            A_T:     mul_a = t_reg[MUL_A_W-1:0];
            A_C3:    mul_a = MUL_A_W'(COEF3);
            A_HB8:   mul_a = MUL_A_W'(t_reg >> 8);
            A_HC24:  mul_a = MUL_A_W'(t_reg >> 24);
            default: mul_a = '0;
        endcase
        unique case (ctl.bsel)
            B_RECIP: mul_b = RECIP_625;
            B_P:     mul_b = MUL_B_W'(p_reg);
            default: mul_b = '0;
        endcase
        a_half = (ctl.op == OP_MUL_HI) ? mul_a[MUL_A_W-1:MUL_HALF_W]
                                       : mul_a[MUL_HALF_W-1:0];
        prod   = a_half * mul_b;
    end

    generate
        if (LUX_FRAC_BITS >= 8) begin : g_p_down
            assign p_scaled = P_W'(l_reg >> (LUX_FRAC_BITS - 8));
        end else begin : g_p_up
            assign p_scaled = P_W'({l_reg, {(8 - LUX_FRAC_BITS){1'b0}}});
        end
    endgenerate

    always_comb begin
        neg     = T_W'(acc_reg >> 24);
        fix_val = acc_reg >> FIX_SHIFT;
        fix_sat = (|fix_val[ACC_W-1:LUX_W]) ? '1 : fix_val[LUX_W-1:0];
    end

    // Next settings; limits are checked in order, first hit wins
    always_comb begin
        ng = gain_idx_reg;
        nt = time_idx_reg;
        if (range_en_reg) begin
            priority if (raw_reg > very_bright_reg) begin
                ng = GAIN_EIGHTH;
                nt = TIME_50MS;
            end else if (raw_reg > bright_reg) begin
                ng = GAIN_QUARTER;
                nt = TIME_100MS;
            end else if (raw_reg < very_dark_reg) begin
                ng = GAIN_X2;
                nt = TIME_800MS;
            end else if (raw_reg < dark_reg) begin
                ng = GAIN_X2;
                nt = TIME_400MS;
            end else begin
                ng = gain_idx_reg;
                nt = time_idx_reg;
            end
        end
        changed = (ng != gain_idx_reg) || (nt != time_idx_reg);
    end

    always_comb begin
        raw_next       = s_xfer ? s_raw_count : raw_reg;
        acc_next       = acc_reg;
        q_next         = q_reg;
        hi_next        = hi_reg;
        x_next         = x_reg;
        l_next         = l_reg;
        p_next         = p_reg;
        t_next         = t_reg;
        gain_idx_next  = gain_idx_reg;
        time_idx_next  = time_idx_reg;
        lux_out_next   = lux_out_reg;
        gain_out_next  = gain_out_reg;
        time_out_next  = time_out_reg;
        ngain_out_next = ngain_out_reg;
        ntime_out_next = ntime_out_reg;
        chg_out_next   = chg_out_reg;
        out_valid_next = out_valid_reg && !m_ready;

        if (step_en) begin
            unique case (ctl.op)
                OP_MUL_LO: acc_next = ACC_W'(prod);
                OP_MUL_HI: acc_next = acc_reg + (ACC_W'(prod) << MUL_HALF_W);
                OP_QUOT: begin
                    q_next  = acc_reg[RECIP_SHIFT +: Q_W];
                    hi_next = (num > HI_LIMIT);
                end
                OP_REM: begin
                    x_next = X_W'(rem10) << shamt;
                    l_next = LIN_W'(q_reg) << shamt;
                end
                OP_LIN:    l_next = l_reg + LIN_W'(acc_reg >> RECIP_SHIFT);
                OP_PSCALE: p_next = p_scaled;
                OP_T1:     t_next = T_W'(acc_reg >> 16);
                OP_POS:    t_next = T_W'(COEF2) + T_W'(acc_reg >> 16);
                OP_HB:     t_next = (t_reg > neg) ? (t_reg - neg) : '0;
                OP_HC:     t_next = T_W'(COEF1) + T_W'(acc_reg);
                OP_FIN_FIX, OP_FIN_LIN: begin
                    lux_out_next   = (ctl.op == OP_FIN_FIX) ? fix_sat : LUX_W'(l_reg);
                    gain_out_next  = gain_idx_reg;
                    time_out_next  = time_idx_reg;
                    ngain_out_next = ng;
                    ntime_out_next = nt;
                    chg_out_next   = changed;
                    gain_idx_next  = ng;
                    time_idx_next  = nt;
                    out_valid_next = 1'b1;
                end
                default: acc_next = acc_reg;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= SEQ_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
            gain_idx_reg  <= GAIN_X1;
            time_idx_reg  <= TIME_100MS;
            hi_reg        <= 1'b0;
        end else begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
            gain_idx_reg  <= gain_idx_next;
            time_idx_reg  <= time_idx_next;
            hi_reg        <= hi_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            very_bright_reg <= VERY_BRIGHT_RST;
            bright_reg      <= BRIGHT_RST;
            very_dark_reg   <= VERY_DARK_RST;
            dark_reg        <= DARK_RST;
            range_en_reg    <= 1'b1;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_VERY_BRIGHT: very_bright_reg <= cfg_data;
                CFG_BRIGHT:      bright_reg      <= cfg_data;
                CFG_VERY_DARK:   very_dark_reg   <= cfg_data;
                CFG_DARK:        dark_reg        <= cfg_data;
                CFG_RANGE_EN:    range_en_reg    <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        raw_reg       <= raw_next;
        acc_reg       <= acc_next;
        q_reg         <= q_next;
        x_reg         <= x_next;
        l_reg         <= l_next;
        p_reg         <= p_next;
        t_reg         <= t_next;
        lux_out_reg   <= lux_out_next;
        gain_out_reg  <= gain_out_next;
        time_out_reg  <= time_out_next;
        ngain_out_reg <= ngain_out_next;
        ntime_out_reg <= ntime_out_next;
        chg_out_reg   <= chg_out_next;
    end

    assign cfg_ready          = 1'b1;
    assign m_valid            = out_valid_reg;
    assign m_lux_fixed        = lux_out_reg;
    assign m_gain_used        = gain_out_reg;
    assign m_time_used        = time_out_reg;
    assign m_next_gain        = ngain_out_reg;
    assign m_next_time        = ntime_out_reg;
    assign m_settings_changed = chg_out_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_done_loads_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_en && ctl.done) |=> m_valid)
        else $error("finished item did not reach the output register");

    a_changed_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_settings_changed ==
                     ((m_next_gain != m_gain_used) || (m_next_time != m_time_used))))
        else $error("settings_changed disagrees with reported settings");

    a_step_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == SEQ_RUN) |-> (step_reg <= LAST_STEP))
        else $error("step counter ran past the program");

    a_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer |=> ((state_reg == SEQ_RUN) && (step_reg == '0)))
        else $error("accepted item did not start the program");

    a_poly_only_high: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == SEQ_RUN) && (step_reg > STEP_JMP) && (step_reg < STEP_LIN_OUT))
        |-> hi_reg)
        else $error("correction steps run for a low-lux sample");

    a_time_range: assert property (@(posedge aclk) disable iff (!aresetn)
        time_idx_reg <= TIME_800MS)
        else $error("integration time index out of range");

endmodule

`default_nettype wire

[test/allux_checker.sv]
`timescale 1ns / 1ps
// Result checker for ambient_light_lux_autorange: follows the config, input and
// result channels, predicts each result and compares it. Uses allux_pkg.
module allux_checker
    import allux_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  logic [RAW_W-1:0]      s_raw_count,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  logic [LUX_W-1:0]      m_lux_fixed,
    input  logic [GAIN_W-1:0]     m_gain_used,
    input  logic [TIME_W-1:0]     m_time_used,
    input  logic [GAIN_W-1:0]     m_next_gain,
    input  logic [TIME_W-1:0]     m_next_time,
    input  logic                  m_settings_changed,
    output int                    errors,
    output int                    pending
);

    localparam int FRAC = LUX_FRAC_BITS_DEF;

    // correction polynomial in integer form: x^4 and x^3 terms scaled 2^64,
    // x^2 and x terms scaled 2^48
    localparam logic [63:0] K4 = 64'd11092950;
    localparam logic [63:0] K3 = 64'd173259199038;
    localparam logic [63:0] K2 = 64'd22936832902;
    localparam logic [63:0] K1 = 64'd282122369157091;
    localparam logic [63:0] LUX_TOP = (64'd1 << LUX_W) - 64'd1;

    typedef struct packed {
        logic [LUX_W-1:0]  lux;
        logic [GAIN_W-1:0] gain_used;
        logic [TIME_W-1:0] time_used;
        logic [GAIN_W-1:0] gain_next;
        logic [TIME_W-1:0] time_next;
        logic              changed;
    } lux_result_t;

    logic [15:0]       lim_very_bright;
    logic [15:0]       lim_bright;
    logic [15:0]       lim_very_dark;
    logic [15:0]       lim_dark;
    logic              auto_range;
    logic [GAIN_W-1:0] gain_now;
    logic [TIME_W-1:0] time_now;
    lux_result_t       lux_expected[$];

    initial begin
        errors  = 0;
        pending = 0;
    end

    function automatic lux_result_t convert_and_range(input logic [15:0] raw,
                                                      input logic [GAIN_W-1:0] g,
                                                      input logic [TIME_W-1:0] t);
        logic [63:0]       num;
        logic [63:0]       lin;
        logic [63:0]       lux_v;
        logic [63:0]       p;
        logic [63:0]       pos;
        logic [63:0]       neg;
        logic [63:0]       hb;
        logic [63:0]       hc;
        int                gsh;
        int                teff;
        int                sh;
        logic [GAIN_W-1:0] ng;
        logic [TIME_W-1:0] nt;
        lux_result_t       r;
        case (g)
            GAIN_EIGHTH:  gsh = 0;
            GAIN_QUARTER: gsh = 1;
            GAIN_X1:      gsh = 3;
            default:      gsh = 4;
        endcase
        // codes past 800 ms behave as 100 ms
        teff = (t > TIME_800MS) ? int'(TIME_100MS) : int'(t);
        sh = FRAC + 5 - teff - gsh;
        num = (64'(raw) * 64'd36) << sh;
        lin = num / 64'd625;
        lux_v = lin;
        if (num > (64'd625000 << FRAC)) begin
            p = (lin << 8) >> FRAC;
            pos = K2 + ((((K4 * p) >> 16) * p) >> 16);
            neg = (K3 * p) >> 24;
            hb = (pos > neg) ? pos - neg : 64'd0;
            hc = K1 + (hb >> 8) * p;
            lux_v = ((hc >> 24) * p) >> (32 - FRAC);
        end
        if (lux_v > LUX_TOP)
            lux_v = LUX_TOP;
        ng = g;
        nt = t;
        if (auto_range) begin
            if (raw > lim_very_bright) begin
                ng = GAIN_EIGHTH;
                nt = TIME_50MS;
            end else if (raw > lim_bright) begin
                ng = GAIN_QUARTER;
                nt = TIME_100MS;
            end else if (raw < lim_very_dark) begin
                ng = GAIN_X2;
                nt = TIME_800MS;
            end else if (raw < lim_dark) begin
                ng = GAIN_X2;
                nt = TIME_400MS;
            end
        end
        r.lux       = lux_v[LUX_W-1:0];
        r.gain_used = g;
        r.time_used = t;
        r.gain_next = ng;
        r.time_next = nt;
        r.changed   = (ng != g) || (nt != t);
        return r;
    endfunction

    function automatic int field_diff(input string what, input logic [63:0] want,
                                      input logic [63:0] got);
        if (want !== got) begin
            $display("%0t %s: expected %0d, got %0d", $time, what, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge aclk) begin : watch
        lux_result_t want;
        int          bad;
        int          delta;
        if (!aresetn) begin
            lim_very_bright = VERY_BRIGHT_RST;
            lim_bright      = BRIGHT_RST;
            lim_very_dark   = VERY_DARK_RST;
            lim_dark        = DARK_RST;
            auto_range      = 1'b1;
            gain_now        = GAIN_X1;
            time_now        = TIME_100MS;
            lux_expected.delete();
            pending <= 0;
        end else begin
            bad = 0;
            delta = 0;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_VERY_BRIGHT: lim_very_bright = cfg_data;
                    CFG_BRIGHT:      lim_bright = cfg_data;
                    CFG_VERY_DARK:   lim_very_dark = cfg_data;
                    CFG_DARK:        lim_dark = cfg_data;
                    CFG_RANGE_EN:    auto_range = cfg_data[0];
                    default: ;
                endcase
            end
            // results belong to older transfers, so check before queuing a new one
            if (m_valid && m_ready) begin
                if (lux_expected.size() == 0) begin
                    $display("%0t result: expected none, got lux %0d", $time, m_lux_fixed);
                    bad = 1;
                end else begin
                    want = lux_expected.pop_front();
                    delta = delta - 1;
                    bad = bad + field_diff("lux_fixed", want.lux, m_lux_fixed);
                    bad = bad + field_diff("gain_used", want.gain_used, m_gain_used);
                    bad = bad + field_diff("time_used", want.time_used, m_time_used);
                    bad = bad + field_diff("next_gain", want.gain_next, m_next_gain);
                    bad = bad + field_diff("next_time", want.time_next, m_next_time);
                    bad = bad + field_diff("settings_changed", want.changed,
                                           m_settings_changed);
                end
            end
            if (s_valid && s_ready) begin
                want = convert_and_range(s_raw_count, gain_now, time_now);
                lux_expected.push_back(want);
                gain_now = want.gain_next;
                time_now = want.time_next;
                delta = delta + 1;
            end
            pending <= pending + delta;
            errors <= errors + bad;
        end
    end

endmodule

[test/tb.sv]
`timescale 1ns / 1ps
// Top of the ambient_light_lux_autorange testbench: clock, reset, stimulus and
// verdict. Depends on allux_pkg, the block and allux_checker.
module tb;
    import allux_pkg::*;

    localparam int STUCK_LIMIT = 4000;
    localparam int DRAIN_GAP   = 30;
    localparam int PHASE_ITEMS = 215;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

    logic                  aclk;
    logic                  aresetn = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [RAW_W-1:0]      s_raw_count = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [LUX_W-1:0]      m_lux_fixed;
    logic [GAIN_W-1:0]     m_gain_used;
    logic [TIME_W-1:0]     m_time_used;
    logic [GAIN_W-1:0]     m_next_gain;
    logic [TIME_W-1:0]     m_next_time;
    logic                  m_settings_changed;

    int          errors;
    int          pending;
    int          stuck = 0;
    int          ready_hold = 0;
    int          results_seen = 0;
    int          sent = 0;
    int          settings = 0;
    bit          quiet = 1'b0;
    logic [15:0] lim [0:3];

    ambient_light_lux_autorange u_top (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_raw_count        (s_raw_count),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_lux_fixed        (m_lux_fixed),
        .m_gain_used        (m_gain_used),
        .m_time_used        (m_time_used),
        .m_next_gain        (m_next_gain),
        .m_next_time        (m_next_time),
        .m_settings_changed (m_settings_changed)
    );

    allux_checker u_check (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_raw_count        (s_raw_count),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_lux_fixed        (m_lux_fixed),
        .m_gain_used        (m_gain_used),
        .m_time_used        (m_time_used),
        .m_next_gain        (m_next_gain),
        .m_next_time        (m_next_time),
        .m_settings_changed (m_settings_changed),
        .errors             (errors),
        .pending            (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // result side: random stall after each transfer
    always @(posedge aclk) begin : ready_gen
        int draw;
        if (!aresetn) begin
            m_ready <= 1'b0;
            ready_hold <= 0;
        end else if (m_valid && m_ready) begin
            draw = quiet ? 0 : $urandom_range(0, 5);
            ready_hold <= draw;
            m_ready <= (draw == 0);
        end else if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
            m_ready <= (ready_hold == 1);
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
                || (cfg_valid && cfg_ready))
            stuck <= 0;
        else
            stuck <= stuck + 1;
        if (m_valid && m_ready)
            results_seen <= results_seen + 1;
        if (stuck == STUCK_LIMIT) begin
            $display("%0t no transfer for %0d cycles", $time, STUCK_LIMIT);
            $display("ambient_light_lux_autorange: mismatch");
            $finish;
        end
    end

    // valid stays up after a transfer; the next call either reuses it or drops it
    task automatic send_raw(input logic [15:0] v);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_raw_count <= v;
        do @(posedge aclk); while (!s_ready);
        sent++;
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        // a further quiet gap after the last result before returning
        repeat (DRAIN_GAP) @(posedge aclk);
    endtask

    task automatic push_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic program_limits(input logic [15:0] vb, input logic [15:0] b,
                                  input logic [15:0] vd, input logic [15:0] d,
                                  input logic en, input bit spare);
        wait_idle();
        push_reg(CFG_VERY_BRIGHT, vb);
        push_reg(CFG_BRIGHT, b);
        push_reg(CFG_VERY_DARK, vd);
        push_reg(CFG_DARK, d);
        push_reg(CFG_RANGE_EN, {15'($urandom), en});
        if (spare)
            push_reg(CFG_SPARE, 16'($urandom));
        cfg_valid <= 1'b0;
        lim[0] = vb;
        lim[1] = b;
        lim[2] = vd;
        lim[3] = d;
        settings++;
    endtask

    function automatic logic [15:0] pick_raw();
        int sel;
        int v;
        sel = $urandom_range(0, 9);
        case (sel)
            4, 5: begin
                v = int'(lim[$urandom_range(0, 3)]) + $urandom_range(0, 4) - 2;
                if (v < 0) v = 0;
                if (v > 65535) v = 65535;
            end
            6: v = $urandom_range(0, 700);
            7: v = $urandom_range(50000, 65535);
            8: v = ($urandom_range(0, 1) == 1) ? 65535 : 0;
            default: v = $urandom_range(0, 65535);
        endcase
        return 16'(v);
    endfunction

    initial begin : stimulus
        int ph;
        int n;
        logic [15:0] vd;
        logic [15:0] b;
        lim[0] = VERY_BRIGHT_RST;
        lim[1] = BRIGHT_RST;
        lim[2] = VERY_DARK_RST;
        lim[3] = DARK_RST;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // reset limits: walk every range step and the limit boundaries
        send_raw(16'd0);     send_raw(16'd65535); send_raw(16'd65535);
        send_raw(16'd60000); send_raw(16'd60001); send_raw(16'd30000);
        send_raw(16'd30001); send_raw(16'd45000); send_raw(16'd1000);
        send_raw(16'd500);   send_raw(16'd499);   send_raw(16'd100);
        send_raw(16'd99);    send_raw(16'h5555);  send_raw(16'hAAAA);
        send_raw(16'd1);     send_raw(16'd12000);

        // ranging held off
        program_limits(VERY_BRIGHT_RST, BRIGHT_RST, VERY_DARK_RST, DARK_RST, 1'b0, 1'b1);
        send_raw(16'd0);     send_raw(16'd65535); send_raw(16'd40000);

        // limits out of order: first test in the list wins
        program_limits(16'd10, 16'd0, 16'd65535, 16'd65535, 1'b1, 1'b0);
        send_raw(16'd5);     send_raw(16'd0);     send_raw(16'd11);

        program_limits(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0);
        send_raw(16'd65535); send_raw(16'd100);

        for (ph = 0; ph < 6; ph++) begin
            case (ph)
                0: program_limits(VERY_BRIGHT_RST, BRIGHT_RST, VERY_DARK_RST, DARK_RST,
                                  1'b1, 1'b0);
                1: program_limits(16'($urandom), 16'($urandom), 16'($urandom),
                                  16'($urandom), 1'b1, 1'b1);
                2: program_limits(16'd0, 16'd0, 16'd0, 16'd0, 1'b1, 1'b0);
                3: program_limits(16'($urandom), 16'($urandom), 16'($urandom),
                                  16'($urandom), 1'b0, 1'b0);
                4: begin
                    vd = 16'($urandom_range(0, 2000));
                    b = 16'($urandom_range(20000, 40000));
                    program_limits(b + 16'($urandom_range(0, 25000)), b, vd,
                                   vd + 16'($urandom_range(0, 3000)), 1'b1, 1'b0);
                end
                default: program_limits(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                        1'b1, 1'b0);
            endcase
            for (n = 0; n < PHASE_ITEMS; n++) begin
                quiet = ph[0] && (n < 60);
                // hold the input until every outstanding result has come back
                if (n == PHASE_ITEMS / 2)
                    wait_idle();
                send_raw(pick_raw());
            end
            quiet = 1'b0;
        end

        wait_idle();
        $display("Sent %0d raw counts under %0d limit settings, %0d results compared.",
                 sent, settings + 1, results_seen);
        if (errors == 0 && pending == 0)
            $display("ambient_light_lux_autorange: match");
        else
            $display("ambient_light_lux_autorange: mismatch");
        $finish;
    end

endmodule

[ambient_light_lux_autorange.f]
design/allux_pkg.sv
design/ambient_light_lux_autorange.sv
test/allux_checker.sv
test/tb.sv
